// ===== hdl/stla_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stla_pkg - shared definitions for the slot table LRU allocator
// Field widths, command codes and parameter defaults.
// ----------------------------------------------------------------------------
package stla_pkg;

    localparam int CMD_W  = 3;
    localparam int ID_W   = 15;
    localparam int AGE_W  = 32;
    localparam int SLOT_W = 5;

    localparam int DEF_SLOTS  = 32;
    localparam int DEF_MAX_ID = 32767;

    typedef logic [CMD_W-1:0] t_cmd;
    typedef logic [ID_W-1:0]  t_id;
    typedef logic [AGE_W-1:0] t_age;

    localparam t_cmd CMD_LOOKUP = 3'd0;
    localparam t_cmd CMD_ALLOC  = 3'd1;
    localparam t_cmd CMD_TOUCH  = 3'd2;
    localparam t_cmd CMD_KILL   = 3'd3;
    localparam t_cmd CMD_CLEAR  = 3'd4;
    localparam t_cmd CMD_SETCUR = 3'd5;

endpackage
`default_nettype wire

// ===== hdl/stla_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stla_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/slot_table_lru_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slot_table_lru_allocator - id slot table with LRU replacement and a pinned id
// Lookup, allocate, touch, kill, clear and pin over SLOTS entries, scanned
// one entry per cycle through an id RAM and an age RAM.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_cmd, i_target_id
//  out     | output    | o_out_valid / i_out_stall  | o_status, o_slot_index,
//          |           |                            | o_result_id, o_evicted,
//          |           |                            | o_evicted_id,
//          |           |                            | o_current_cleared
//
//  Lookup, touch and kill end the scan at a match and allocate at the first empty
//  slot, while clear always scans every slot; the scan reads one slot per cycle
//  from the RAMs and compares it in a single id/age compare unit. Set current
//  and unknown codes skip the scan.
//  Synchronous active-low reset empties every slot at once through per-slot
//  valid bits. A result held by i_out_stall holds the block in its final step;
//  the next item is accepted while an earlier result is still waiting.
// ----------------------------------------------------------------------------
module slot_table_lru_allocator
    import stla_pkg::*;
#(
    parameter int SLOTS  = DEF_SLOTS,
    parameter int MAX_ID = DEF_MAX_ID
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [CMD_W-1:0]  i_cmd,
    input  wire logic [ID_W-1:0]   i_target_id,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_status,
    output logic      [SLOT_W-1:0] o_slot_index,
    output logic      [ID_W-1:0]   o_result_id,
    output logic                   o_evicted,
    output logic      [ID_W-1:0]   o_evicted_id,
    output logic                   o_current_cleared
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    // control state
    logic [1:0]       r_state, n_state;
    logic [SLOTS-1:0] r_valid, n_valid;
    t_id              r_next_id, n_next_id;
    t_age             r_age_cnt, n_age_cnt;
    t_id              r_cur, n_cur;
    logic             r_out_valid, n_out_valid;

    // item and scan registers
    t_cmd             r_cmd, n_cmd;
    t_id              r_tid, n_tid;
    logic [CW-1:0]    r_addr, n_addr;
    logic             r_dv, n_dv;
    logic [IW-1:0]    r_didx, n_didx;
    logic             r_found, n_found;
    logic [IW-1:0]    r_sel, n_sel;
    t_age             r_best_age, n_best_age;
    logic [IW-1:0]    r_best_idx, n_best_idx;
    t_id              r_best_id, n_best_id;
    logic             r_cc, n_cc;

    // result registers
    logic              r_status, n_status;
    logic [SLOT_W-1:0] r_slot, n_slot;
    t_id               r_rid, n_rid;
    logic              r_ev, n_ev;
    t_id               r_evid, n_evid;
    logic              r_occ, n_occ;

    // RAM ports
    logic          id_we, age_we;
    logic [IW-1:0] wslot;
    t_id           rd_id;
    t_age          rd_age;

    logic          in_acc, out_free, issue, scan_done;
    logic          rd_valid, hit, is_find;
    logic [IW-1:0] a_slot;
    logic          a_cc;

    stla_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (id_we),
        .i_waddr (wslot),
        .i_wdata (r_next_id),
        .i_raddr (r_addr[IW-1:0]),
        .o_rdata (rd_id)
    );

    stla_ram #(.WIDTH(AGE_W), .DEPTH(SLOTS)) u_age_ram (
        .i_clk   (i_clk),
        .i_we    (age_we),
        .i_waddr (wslot),
        .i_wdata (r_age_cnt),
        .i_raddr (r_addr[IW-1:0]),
        .o_rdata (rd_age)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign is_find  = (r_cmd == CMD_LOOKUP) || (r_cmd == CMD_TOUCH) || (r_cmd == CMD_KILL);
    assign rd_valid = r_valid[r_didx];
    assign hit      = rd_valid && (rd_id == r_tid);

    always_comb begin
        scan_done = 1'b0;
        if (r_dv) begin
            scan_done = (r_didx == IW'(SLOTS - 1))
                     || (is_find && hit)
                     || ((r_cmd == CMD_ALLOC) && !rd_valid);
        end
    end

    assign issue = (r_state == ST_SCAN) && (r_addr != CW'(SLOTS)) && !scan_done;

    // allocate target: first empty slot, else the oldest unpinned one
    assign a_slot = r_found ? r_sel : r_best_idx;
    assign a_cc   = !r_found && (r_best_id == r_cur);

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_next_id   = r_next_id;
        n_age_cnt   = r_age_cnt;
        n_cur       = r_cur;
        n_out_valid = r_out_valid && i_out_stall;
        n_cmd       = r_cmd;
        n_tid       = r_tid;
        n_addr      = r_addr;
        n_dv        = r_dv;
        n_didx      = r_didx;
        n_found     = r_found;
        n_sel       = r_sel;
        n_best_age  = r_best_age;
        n_best_idx  = r_best_idx;
        n_best_id   = r_best_id;
        n_cc        = r_cc;
        n_status    = r_status;
        n_slot      = r_slot;
        n_rid       = r_rid;
        n_ev        = r_ev;
        n_evid      = r_evid;
        n_occ       = r_occ;
        id_we       = 1'b0;
        age_we      = 1'b0;
        wslot       = r_sel;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_cmd      = i_cmd;
                    n_tid      = i_target_id;
                    n_addr     = '0;
                    n_dv       = 1'b0;
                    n_found    = 1'b0;
                    n_sel      = '0;
                    n_best_age = '1;
                    n_best_idx = '0;
                    n_best_id  = '0;
                    n_cc       = 1'b0;
                    if ((i_cmd == CMD_SETCUR) || (i_cmd > CMD_SETCUR)) begin
                        n_state = ST_UPDATE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                n_dv = issue;
                if (issue) begin
                    n_addr = r_addr + CW'(1);
                    n_didx = r_addr[IW-1:0];
                end
                if (r_dv) begin
                    // slot 0 is the fallback victim when every slot is pinned
                    if (r_didx == '0) begin
                        n_best_id = rd_valid ? rd_id : '0;
                    end
                    case (r_cmd)
                        CMD_LOOKUP, CMD_TOUCH, CMD_KILL: begin
                            if (hit) begin
                                n_found = 1'b1;
                                n_sel   = r_didx;
                            end
                        end
                        CMD_ALLOC: begin
                            if (!rd_valid) begin
                                n_found = 1'b1;
                                n_sel   = r_didx;
                            end else if ((rd_id != r_cur) && !(rd_age > r_best_age)) begin
                                // ties go to the later slot
                                n_best_age = rd_age;
                                n_best_idx = r_didx;
                                n_best_id  = rd_id;
                            end
                        end
                        CMD_CLEAR: begin
                            if (rd_valid && (rd_id == r_cur)) begin
                                n_cc = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                if (scan_done) begin
                    n_state = ST_UPDATE;
                end
            end

            ST_UPDATE: begin
                if (out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = 1'b0;
                    n_slot      = '0;
                    n_rid       = '0;
                    n_ev        = 1'b0;
                    n_evid      = '0;
                    n_occ       = 1'b0;
                    case (r_cmd)
                        CMD_LOOKUP, CMD_TOUCH, CMD_KILL: begin
                            if (!r_found) begin
                                n_status = 1'b1;
                            end else begin
                                n_slot = SLOT_W'(r_sel);
                                n_rid  = r_tid;
                                if (r_cmd == CMD_TOUCH) begin
                                    age_we    = 1'b1;
                                    n_age_cnt = r_age_cnt + AGE_W'(1);
                                end else if (r_cmd == CMD_KILL) begin
                                    n_valid[r_sel] = 1'b0;
                                    if (r_tid == r_cur) begin
                                        n_cur = '0;
                                        n_occ = 1'b1;
                                    end
                                end
                            end
                        end
                        CMD_ALLOC: begin
                            wslot          = a_slot;
                            id_we          = 1'b1;
                            age_we         = 1'b1;
                            n_valid[a_slot] = 1'b1;
                            n_age_cnt      = r_age_cnt + AGE_W'(1);
                            n_next_id      = (r_next_id < ID_W'(MAX_ID))
                                           ? r_next_id + ID_W'(1) : ID_W'(1);
                            n_slot         = SLOT_W'(a_slot);
                            n_rid          = r_next_id;
                            n_ev           = !r_found;
                            n_evid         = r_found ? '0 : r_best_id;
                            n_occ          = a_cc;
                            if (a_cc) begin
                                n_cur = '0;
                            end
                        end
                        CMD_CLEAR: begin
                            n_valid   = '0;
                            n_age_cnt = AGE_W'(1);
                            n_occ     = r_cc;
                            if (r_cc) begin
                                n_cur = '0;
                            end
                        end
                        CMD_SETCUR: begin
                            n_cur = r_tid;
                            n_rid = r_tid;
                        end
                        default: begin
                            n_status = 1'b1;
                        end
                    endcase
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_next_id   <= ID_W'(1);
            r_age_cnt   <= AGE_W'(1);
            r_cur       <= '0;
            r_out_valid <= 1'b0;
            r_dv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_next_id   <= n_next_id;
            r_age_cnt   <= n_age_cnt;
            r_cur       <= n_cur;
            r_out_valid <= n_out_valid;
            r_dv        <= n_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_tid      <= n_tid;
        r_addr     <= n_addr;
        r_didx     <= n_didx;
        r_found    <= n_found;
        r_sel      <= n_sel;
        r_best_age <= n_best_age;
        r_best_idx <= n_best_idx;
        r_best_id  <= n_best_id;
        r_cc       <= n_cc;
        r_status   <= n_status;
        r_slot     <= n_slot;
        r_rid      <= n_rid;
        r_ev       <= n_ev;
        r_evid     <= n_evid;
        r_occ      <= n_occ;
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_slot_index      = r_slot;
    assign o_result_id       = r_rid;
    assign o_evicted         = r_ev;
    assign o_evicted_id      = r_evid;
    assign o_current_cleared = r_occ;

endmodule
`default_nettype wire
